@@ design/mwf_pkg.sv @@
// shared constants and types for the median window filter
package mwf_pkg;

  // field and register widths
  localparam int DATA_W   = 16;
  localparam int UPPER_W  = 17;
  localparam int LOWER_W  = 16;
  localparam int CFG_W    = 17;
  localparam int CFG_IDX_W = 1;

  // default window depth
  localparam int WINDOW_SIZE_DEF = 31;

  // register reset values
  localparam logic [UPPER_W-1:0] UPPER_RESET = UPPER_W'(15000);
  localparam logic [LOWER_W-1:0] LOWER_RESET = '0;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER = 1'b1;

  // control from the sequencer to the rank selector
  typedef struct packed {
    logic start;
    logic step;
  } mwf_sel_ctrl_t;

endpackage

@@ design/mwf_rank_sel.sv @@
// bit-serial rank selector: finds the median one bit per cycle while ctrl.step is high, msb first
module mwf_rank_sel #(
  parameter int WINDOW_SIZE = mwf_pkg::WINDOW_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mwf_pkg::mwf_sel_ctrl_t      ctrl,
  input  logic [WINDOW_SIZE-1:0]      msb,
  output logic [mwf_pkg::DATA_W-1:0]  median
);
  import mwf_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
  localparam logic [CNT_W-1:0] KMED = CNT_W'((WINDOW_SIZE - 1) / 2);

  logic [WINDOW_SIZE-1:0] cand;
  logic [WINDOW_SIZE-1:0] zeros;
  logic [CNT_W-1:0]       rank;
  logic [CNT_W-1:0]       zero_cnt;
  logic                   bit_one;

  // candidates whose current bit is zero, and how many there are
  always_comb begin
    zeros    = cand & ~msb;
    zero_cnt = CNT_W'($countones(zeros));
    bit_one  = (rank >= zero_cnt);
  end

  // narrow the candidate set by one bit per step
  always_ff @(posedge clk) begin
    if (rst) begin
      cand <= '0;
      rank <= '0;
    end else if (ctrl.start) begin
      cand <= '1;
      rank <= KMED;
    end else if (ctrl.step) begin
      if (bit_one) begin
        cand <= cand & msb;
        rank <= rank - zero_cnt;
      end else begin
        cand <= zeros;
      end
    end
  end

  // median bits shift in msb first
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      median <= {median[DATA_W-2:0], bit_one};
    end
  end

endmodule

@@ design/median_window_filter_with_cutoff.sv @@
// top level of the sliding window median filter with cut-off limits
//
// Input channel: sample with in_valid / in_stall. A transaction is taken
// when in_valid is high and in_stall is low; in_stall is high while an
// item is being worked on.
// Output channel: filtered_value and cut_off with out_valid / out_stall.
// Each input transaction yields exactly one output transaction.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 upper
// limit, 1 lower limit); write only while the block is idle.
// Timing: the window holds one 16-bit shift lane per entry; the median is
// found one bit per cycle, msb first, so an item is loaded on acceptance,
// selected bit by bit in the selection state and registered in the done
// state, which raises out_valid once the output register is free; the next
// item is taken only after the block has returned to idle.
// A result waiting in the output register does not block the next input;
// a second result waits in the last stage until the output register frees.
// Reset clears the window to zero, the write position, the limits to their
// defaults (upper 15000, lower 0) and empties the output register.
module median_window_filter_with_cutoff #(
  parameter int WINDOW_SIZE = mwf_pkg::WINDOW_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mwf_pkg::DATA_W-1:0]     sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mwf_pkg::DATA_W-1:0]     filtered_value,
  output logic                           cut_off,
  input  logic                           cfg_we,
  input  logic [mwf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mwf_pkg::CFG_W-1:0]      cfg_data
);
  import mwf_pkg::*;

  localparam int POS_W = $clog2(WINDOW_SIZE);
  localparam int BIT_W = $clog2(DATA_W);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_SIZE - 1);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(DATA_W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SELECT,
    ST_DONE
  } state_t;

  state_t                 state;
  logic [BIT_W-1:0]       bit_cnt;
  logic [POS_W-1:0]       write_pos;
  logic [UPPER_W-1:0]     upper_limit;
  logic [LOWER_W-1:0]     lower_limit;
  logic [DATA_W-1:0]      lane [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0] msb;
  logic [DATA_W-1:0]      median;
  mwf_sel_ctrl_t          sel_ctrl;
  logic                   accept;
  logic                   out_free;
  logic                   cut;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign sel_ctrl.start = accept;
  assign sel_ctrl.step  = (state == ST_SELECT);

  // limit check on the finished median
  assign cut = ({1'b0, median} >= upper_limit) || (median <= lower_limit);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit <= UPPER_RESET;
      lower_limit <= LOWER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UPPER: upper_limit <= cfg_data[UPPER_W-1:0];
        REG_LOWER: lower_limit <= cfg_data[LOWER_W-1:0];
        default: ;
      endcase
    end
  end

  // window lanes: load at the write position, rotate during selection
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        lane[i] <= '0;
      end
    end else if (accept) begin
      lane[write_pos] <= sample;
    end else if (state == ST_SELECT) begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        lane[i] <= {lane[i][DATA_W-2:0], lane[i][DATA_W-1]};
      end
    end
  end

  // msb tap of each lane
  always_comb begin
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      msb[i] = lane[i][DATA_W-1];
    end
  end

  // circular write position
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos <= '0;
    end else if (accept) begin
      write_pos <= (write_pos == POS_LAST) ? '0 : write_pos + 1'b1;
    end
  end

  mwf_rank_sel #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_rank_sel (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (sel_ctrl),
    .msb    (msb),
    .median (median)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bit_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            bit_cnt <= '0;
            state   <= ST_SELECT;
          end
        end
        ST_SELECT: begin
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == BIT_LAST) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            filtered_value <= cut ? '0 : median;
            cut_off        <= cut;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ design/mwf_checker.sv @@
// port-level checks for the median window filter, bound to the top level
module mwf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [mwf_pkg::DATA_W-1:0] filtered_value,
  input logic                       cut_off
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(filtered_value) && $stable(cut_off))
    else $error("stalled result changed or dropped");

  // a cut-off result carries zero
  a_cut_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && cut_off |-> filtered_value == '0)
    else $error("cut-off result is not zero");

  // a passed median is never zero, since the lower limit check catches it
  a_pass_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cut_off |-> filtered_value != '0)
    else $error("zero median passed without cut-off");

  // after a transaction the block is busy with it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transaction");

endmodule

bind median_window_filter_with_cutoff mwf_checker u_mwf_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .filtered_value (filtered_value),
  .cut_off        (cut_off)
);
